// ----- hdl/tachometer_rpm_display_assert.svh -----
// ----------------------------------------------------------------------------
// Tachometer assertion macros
// Concurrent check macros for the tachometer; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef TACHOMETER_RPM_DISPLAY_ASSERT_SVH
`define TACHOMETER_RPM_DISPLAY_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, clocked on clk, off during reset.
`define TACH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, clocked on clk, off during reset.
`define TACH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TACH_ASSERT_IMPL(lbl, ante, cons, msg)
`define TACH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/tach_pkg.sv -----
// ----------------------------------------------------------------------------
// Tachometer package
// Widths, reset values, register codes and controller types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tach_pkg;

    localparam int TIME_BITS_DEF   = 32;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int TS_W       = 32;
    localparam int THR_W      = 12;
    localparam int EPM_W      = 8;
    localparam int CLK_HZ_W   = 27;
    localparam int PERIOD_W   = 16;
    localparam int DUTY_W     = 13;
    localparam int RPM_W      = 14;
    localparam int DIGIT_W    = 4;
    localparam int PULSE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    // 60 * clock_hz needs six more bits than clock_hz
    localparam int NUM_W      = CLK_HZ_W + 6;
    localparam int BCD_DIGITS = 4;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int CNT_W      = $clog2(NUM_W);
    localparam int SETTLE_CYCLES = 2;

    // floor(x / 10000) = (x * PWM_RECIP) >> PWM_SHIFT, exact for x < 2^29
    localparam int RECIP_W   = 30;
    localparam int PWM_SHIFT = 43;
    localparam int MULT_W    = DUTY_W + PERIOD_W;
    localparam int PROD_W    = MULT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] PWM_RECIP = 30'd879609303;

    localparam logic [THR_W-1:0]    HIGH_THR_RST = 12'd2000;
    localparam logic [THR_W-1:0]    LOW_THR_RST  = 12'd800;
    localparam logic [EPM_W-1:0]    EPM_RST      = 8'd5;
    localparam logic [CLK_HZ_W-1:0] CLK_HZ_RST   = 27'd40000000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 16'd31;
    localparam logic [DUTY_W-1:0]   DUTY_MIN_RST = 13'd450;
    localparam logic [DUTY_W-1:0]   DUTY_MAX_RST = 13'd7000;
    localparam logic [DUTY_W-1:0]   DUTY_RST     = 13'd500;
    localparam logic [RPM_W-1:0]    RPM_CAP      = 14'd9999;
    localparam logic [RPM_W-1:0]    RPM_FOUR_DIGIT = 14'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIGH_THR   = 3'd0,
        REG_LOW_THR    = 3'd1,
        REG_EDGES      = 3'd2,
        REG_CLOCK_HZ   = 3'd3,
        REG_PWM_PERIOD = 3'd4,
        REG_DUTY_MIN   = 3'd5,
        REG_DUTY_MAX   = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_ROUND,
        ST_BCD,
        ST_SETTLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic div_step;
        logic round;
        logic bcd_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic meas_due;
    } status_t;

endpackage

`default_nettype wire

// ----- hdl/tachometer_rpm_display.sv -----
// ----------------------------------------------------------------------------
// Tachometer with rpm display
// Period-measuring tachometer: hysteresis edge detect, rpm by iterative
// division, three-digit BCD readout and button-stepped PWM pulse width.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall   sample, timestamp, button_down,
//                                           button_up
//   out      source     out_valid/out_stall rpm, digit_left, digit_middle,
//                                           digit_right, pulse_width, measured
//   cfg      sink       cfg_we              cfg_index, cfg_data
//
// An item with no completed measurement goes, from one acceptance to the
// next, through capture, evaluate, the wait through the pulse-width
// multiplier pair and result load.
// An item that completes a measurement goes through capture, evaluate,
// the 33-step restoring divider, rounding, the 14-step BCD converter and
// result load.
// Reset clears the tracking state (duty to its default) and loads register defaults; no sweep.
// A stalled result waits in the output register; the block takes the next
// item meanwhile and holds its own result until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tachometer_rpm_display_assert.svh"

module tachometer_rpm_display
#(
    parameter int TIME_BITS   = tach_pkg::TIME_BITS_DEF,
    parameter int SAMPLE_BITS = tach_pkg::SAMPLE_BITS_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [tach_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tach_pkg::CFG_DATA_W-1:0] cfg_data,

    // input items
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [SAMPLE_BITS-1:0]          sample,
    input  wire logic [tach_pkg::TS_W-1:0]       timestamp,
    input  wire logic                            button_down,
    input  wire logic                            button_up,

    // result items
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [tach_pkg::RPM_W-1:0]           rpm,
    output logic [tach_pkg::DIGIT_W-1:0]         digit_left,
    output logic [tach_pkg::DIGIT_W-1:0]         digit_middle,
    output logic [tach_pkg::DIGIT_W-1:0]         digit_right,
    output logic [tach_pkg::PULSE_W-1:0]         pulse_width,
    output logic                                 measured
);

    tach_pkg::cmd_t    cmd;
    tach_pkg::status_t status;
    logic              out_in_range;

    // controller: sequences each item through the datapath
    tach_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: registers, divider, BCD converter, PWM scaling, result register
    tach_dp
    #(
        .TIME_BITS   (TIME_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .timestamp    (timestamp),
        .button_down  (button_down),
        .button_up    (button_up),
        .cmd          (cmd),
        .status       (status),
        .rpm          (rpm),
        .digit_left   (digit_left),
        .digit_middle (digit_middle),
        .digit_right  (digit_right),
        .pulse_width  (pulse_width),
        .measured     (measured)
    );

    // saturation and digit range of the presented item
    assign out_in_range = (rpm <= tach_pkg::RPM_CAP) && (digit_left <= 4'd9)
                          && (digit_middle <= 4'd9) && (digit_right <= 4'd9);

    // an accepted item makes the block busy in the next cycle
    `TACH_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "accept left block idle")
    // at most one datapath command at a time
    `TACH_ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0(cmd), "datapath commands overlap")
    // load a result only into a free output register
    `TACH_ASSERT_IMPL(a_emit_free, cmd.emit, !out_valid || !out_stall, "emit into full register")
    // a loaded result shows up as valid
    `TACH_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid, "loaded result not presented")
    // saturation and digit range hold on every presented item
    `TACH_ASSERT_IMPL(a_out_range, out_valid, out_in_range, "result out of range")

endmodule

`default_nettype wire

// ----- hdl/tach_ctrl.sv -----
// ----------------------------------------------------------------------------
// Tachometer controller
// Sequences capture, evaluation, division, digit split and result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tach_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire tach_pkg::status_t status,
    output tach_pkg::cmd_t         cmd
);

    tach_pkg::state_t               state_reg, state_next;
    logic [tach_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tach_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            tach_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = tach_pkg::ST_EVAL;
                end
            end
            tach_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
                cnt_next = '0;
                state_next = status.meas_due ? tach_pkg::ST_DIV : tach_pkg::ST_SETTLE;
            end
            tach_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == tach_pkg::CNT_W'(tach_pkg::NUM_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = tach_pkg::ST_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tach_pkg::ST_ROUND:
            begin
                cmd.round  = 1'b1;
                cnt_next   = '0;
                state_next = tach_pkg::ST_BCD;
            end
            tach_pkg::ST_BCD:
            begin
                cmd.bcd_step = 1'b1;
                if (cnt_reg == tach_pkg::CNT_W'(tach_pkg::RPM_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = tach_pkg::ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tach_pkg::ST_SETTLE:
            begin
                // wait for the pulse-width multiplier pair
                if (cnt_reg == tach_pkg::CNT_W'(tach_pkg::SETTLE_CYCLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = tach_pkg::ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tach_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = tach_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tach_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_stall  = (state_reg != tach_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- hdl/tach_dp.sv -----
// ----------------------------------------------------------------------------
// Tachometer datapath
// Config registers, level tracking, restoring divider, BCD split, PWM scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tach_dp
#(
    parameter int TIME_BITS   = tach_pkg::TIME_BITS_DEF,
    parameter int SAMPLE_BITS = tach_pkg::SAMPLE_BITS_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [tach_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tach_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [SAMPLE_BITS-1:0]          sample,
    input  wire logic [tach_pkg::TS_W-1:0]       timestamp,
    input  wire logic                            button_down,
    input  wire logic                            button_up,
    input  wire tach_pkg::cmd_t                  cmd,
    output tach_pkg::status_t                    status,
    output logic [tach_pkg::RPM_W-1:0]           rpm,
    output logic [tach_pkg::DIGIT_W-1:0]         digit_left,
    output logic [tach_pkg::DIGIT_W-1:0]         digit_middle,
    output logic [tach_pkg::DIGIT_W-1:0]         digit_right,
    output logic [tach_pkg::PULSE_W-1:0]         pulse_width,
    output logic                                 measured
);

    localparam int CMP_W = (SAMPLE_BITS > tach_pkg::THR_W) ? SAMPLE_BITS : tach_pkg::THR_W;
    localparam int NUM_W = tach_pkg::NUM_W;
    localparam int RPM_W = tach_pkg::RPM_W;
    localparam int DUTY_W = tach_pkg::DUTY_W;
    localparam int DIGIT_W = tach_pkg::DIGIT_W;

    // configuration
    logic [tach_pkg::THR_W-1:0]    high_thr_reg, low_thr_reg;
    logic [tach_pkg::EPM_W-1:0]    edges_reg;
    logic [tach_pkg::CLK_HZ_W-1:0] clock_hz_reg;
    logic [tach_pkg::PERIOD_W-1:0] period_reg;
    logic [DUTY_W-1:0]             duty_min_reg, duty_max_reg;

    // captured item
    logic [SAMPLE_BITS-1:0]        sample_reg;
    logic [TIME_BITS-1:0]          now_reg;
    logic                          down_reg, up_reg;

    // tracking state
    logic                          level_reg;
    logic [tach_pkg::EPM_W-1:0]    count_reg;
    logic [TIME_BITS-1:0]          start_reg;
    logic [RPM_W-1:0]              rpm_value_reg;
    logic [DUTY_W-1:0]             duty_reg;
    logic [tach_pkg::BCD_W-1:0]    bcd_reg;
    logic                          meas_reg;

    // divider and converter
    logic [NUM_W-1:0]              quo_reg;
    logic [TIME_BITS-1:0]          rem_reg;
    logic [TIME_BITS-1:0]          divisor_reg;
    logic                          zero_reg;
    logic [RPM_W-1:0]              bin_reg;

    // pulse-width scaling
    logic [tach_pkg::MULT_W-1:0]   mult_reg;
    logic [tach_pkg::PROD_W-1:0]   prod_reg;

    // result register
    logic [RPM_W-1:0]              rpm_out_reg;
    logic [DIGIT_W-1:0]            left_reg, middle_reg, right_reg;
    logic [tach_pkg::PULSE_W-1:0]  pulse_reg;
    logic                          measured_reg;

    logic [tach_pkg::TS_W+TIME_BITS-1:0] ts_ext;
    logic [CMP_W-1:0]              smp_ext;
    logic                          cls;
    logic                          change;
    logic [tach_pkg::EPM_W-1:0]    count_inc;
    logic                          meas_due;
    logic [TIME_BITS-1:0]          start_eff;
    logic [TIME_BITS-1:0]          elapsed;
    logic [NUM_W-1:0]              num;
    logic [DUTY_W-1:0]             duty_dn;
    logic [DUTY_W:0]               duty_inc;
    logic [DUTY_W-1:0]             duty_next;
    logic [TIME_BITS:0]            trial;
    logic [TIME_BITS:0]            trial_diff;
    logic                          trial_ge;
    logic                          round_up;
    logic [RPM_W-1:0]              rpm_round;
    logic [tach_pkg::BCD_W-1:0]    bcd_adj;

    assign ts_ext = {{TIME_BITS{1'b0}}, timestamp};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg <= tach_pkg::HIGH_THR_RST;
            low_thr_reg  <= tach_pkg::LOW_THR_RST;
            edges_reg    <= tach_pkg::EPM_RST;
            clock_hz_reg <= tach_pkg::CLK_HZ_RST;
            period_reg   <= tach_pkg::PERIOD_RST;
            duty_min_reg <= tach_pkg::DUTY_MIN_RST;
            duty_max_reg <= tach_pkg::DUTY_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (tach_pkg::cfg_reg_t'(cfg_index))
                tach_pkg::REG_HIGH_THR:   high_thr_reg <= cfg_data[tach_pkg::THR_W-1:0];
                tach_pkg::REG_LOW_THR:    low_thr_reg  <= cfg_data[tach_pkg::THR_W-1:0];
                tach_pkg::REG_EDGES:      edges_reg    <= cfg_data[tach_pkg::EPM_W-1:0];
                tach_pkg::REG_CLOCK_HZ:   clock_hz_reg <= cfg_data[tach_pkg::CLK_HZ_W-1:0];
                tach_pkg::REG_PWM_PERIOD: period_reg   <= cfg_data[tach_pkg::PERIOD_W-1:0];
                tach_pkg::REG_DUTY_MIN:   duty_min_reg <= cfg_data[DUTY_W-1:0];
                tach_pkg::REG_DUTY_MAX:   duty_max_reg <= cfg_data[DUTY_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
            now_reg    <= ts_ext[TIME_BITS-1:0];
            down_reg   <= button_down;
            up_reg     <= button_up;
        end
    end

    // classify with hysteresis; the high test wins
    always_comb
    begin
        smp_ext = CMP_W'(sample_reg);
        if (smp_ext > CMP_W'(high_thr_reg))
            cls = 1'b0;
        else if (smp_ext < CMP_W'(low_thr_reg))
            cls = 1'b1;
        else
            cls = level_reg;
    end

    assign change    = (cls != level_reg);
    assign count_inc = count_reg + 1'b1;
    assign meas_due  = change && (count_inc >= edges_reg);
    assign start_eff = (count_reg == '0) ? now_reg : start_reg;
    assign elapsed   = now_reg - start_eff;
    assign num       = (NUM_W'(clock_hz_reg) << 6) - (NUM_W'(clock_hz_reg) << 2);

    assign status.meas_due = meas_due;

    // down step first, then up step
    always_comb
    begin
        duty_dn = duty_reg;
        if (down_reg)
        begin
            if (duty_reg == '0 || (duty_reg - 1'b1) < duty_min_reg)
                duty_dn = duty_min_reg;
            else
                duty_dn = duty_reg - 1'b1;
        end
        duty_inc  = {1'b0, duty_dn} + 1'b1;
        duty_next = duty_dn;
        if (up_reg)
        begin
            if (duty_inc > {1'b0, duty_max_reg})
                duty_next = duty_max_reg;
            else
                duty_next = duty_inc[DUTY_W-1:0];
        end
    end

    // restoring division step
    assign trial      = {rem_reg, quo_reg[NUM_W-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign trial_ge   = (trial >= {1'b0, divisor_reg});

    // round half up, saturate; zero elapsed saturates
    assign round_up = ({rem_reg, 1'b0} >= {1'b0, divisor_reg});
    always_comb
    begin
        if (zero_reg || quo_reg >= NUM_W'(tach_pkg::RPM_CAP))
            rpm_round = tach_pkg::RPM_CAP;
        else
            rpm_round = quo_reg[RPM_W-1:0] + RPM_W'(round_up);
    end

    // double-dabble adjust
    always_comb
    begin
        for (int i = 0; i < tach_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            else
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= 1'b0;
            count_reg     <= '0;
            start_reg     <= '0;
            rpm_value_reg <= '0;
            duty_reg      <= tach_pkg::DUTY_RST;
            bcd_reg       <= '0;
            meas_reg      <= 1'b0;
        end
        else if (cmd.eval)
        begin
            level_reg <= cls;
            meas_reg  <= meas_due;
            duty_reg  <= duty_next;
            if (change)
            begin
                if (count_reg == '0)
                    start_reg <= now_reg;
                count_reg <= meas_due ? '0 : count_inc;
            end
            else if (duty_reg == duty_max_reg)
            begin
                rpm_value_reg <= '0;
                bcd_reg       <= '0;
            end
        end
        else if (cmd.round)
        begin
            rpm_value_reg <= rpm_round;
            bcd_reg       <= '0;
        end
        else if (cmd.bcd_step)
        begin
            bcd_reg <= {bcd_adj[tach_pkg::BCD_W-2:0], bin_reg[RPM_W-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            quo_reg     <= num;
            rem_reg     <= '0;
            divisor_reg <= elapsed;
            zero_reg    <= (elapsed == '0);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], trial_ge};
        end
        if (cmd.round)
            bin_reg <= rpm_round;
        else if (cmd.bcd_step)
            bin_reg <= {bin_reg[RPM_W-2:0], 1'b0};
    end

    // two registered multiplies: duty*period, then times the reciprocal of 10000
    always_ff @(posedge clk)
    begin
        mult_reg <= tach_pkg::MULT_W'(duty_reg) * tach_pkg::MULT_W'(period_reg);
        prod_reg <= tach_pkg::PROD_W'(mult_reg) * tach_pkg::PROD_W'(tach_pkg::PWM_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rpm_out_reg  <= rpm_value_reg;
            measured_reg <= meas_reg;
            pulse_reg    <= prod_reg[tach_pkg::PWM_SHIFT +: tach_pkg::PULSE_W];
            if (rpm_value_reg >= tach_pkg::RPM_FOUR_DIGIT)
            begin
                left_reg   <= bcd_reg[3*DIGIT_W +: DIGIT_W];
                middle_reg <= bcd_reg[2*DIGIT_W +: DIGIT_W];
                right_reg  <= bcd_reg[DIGIT_W +: DIGIT_W];
            end
            else
            begin
                left_reg   <= bcd_reg[2*DIGIT_W +: DIGIT_W];
                middle_reg <= bcd_reg[DIGIT_W +: DIGIT_W];
                right_reg  <= bcd_reg[0 +: DIGIT_W];
            end
        end
    end

    assign rpm          = rpm_out_reg;
    assign digit_left   = left_reg;
    assign digit_middle = middle_reg;
    assign digit_right  = right_reg;
    assign pulse_width  = pulse_reg;
    assign measured     = measured_reg;

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tachometer rpm display testbench
// Drives sensor samples, timestamps and button presses into the tachometer,
// predicts each readout (rpm, three display digits, pulse width, measured
// flag) from a local copy of the tracking state and registers, and compares
// every result item against the oldest prediction. Random gaps on both
// channels, one long output hold-off and one drain pause load the pipeline.
// ----------------------------------------------------------------------------

module testbench;

    localparam int SMP_W      = tach_pkg::SAMPLE_BITS_DEF;
    localparam int CFG_IDX_W  = tach_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = tach_pkg::CFG_DATA_W;
    localparam int TS_W       = tach_pkg::TS_W;
    localparam int THR_W      = tach_pkg::THR_W;
    localparam int EPM_W      = tach_pkg::EPM_W;
    localparam int CLK_HZ_W   = tach_pkg::CLK_HZ_W;
    localparam int PERIOD_W   = tach_pkg::PERIOD_W;
    localparam int DUTY_W     = tach_pkg::DUTY_W;
    localparam int RPM_W      = tach_pkg::RPM_W;
    localparam int DIGIT_W    = tach_pkg::DIGIT_W;
    localparam int PULSE_W    = tach_pkg::PULSE_W;

    localparam int SMP_MAX = (1 << SMP_W) - 1;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 80;
    // slowest run is about 1800 items, each through the full measurement path plus gaps; allow five times that
    localparam longint TIMEOUT_NS = 64'd6_000_000;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef enum logic [1:0] {
        ZONE_ABOVE,
        ZONE_BELOW,
        ZONE_BAND
    } zone_t;

    typedef struct packed {
        logic [RPM_W-1:0]   rpm;
        logic [DIGIT_W-1:0] dig_left;
        logic [DIGIT_W-1:0] dig_middle;
        logic [DIGIT_W-1:0] dig_right;
        logic [PULSE_W-1:0] pulse;
        logic               measured;
    } readout_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [SMP_W-1:0]      sample;
    logic [TS_W-1:0]       timestamp;
    logic                  button_down;
    logic                  button_up;
    logic                  out_valid;
    logic                  out_stall;
    logic [RPM_W-1:0]      rpm;
    logic [DIGIT_W-1:0]    digit_left;
    logic [DIGIT_W-1:0]    digit_middle;
    logic [DIGIT_W-1:0]    digit_right;
    logic [PULSE_W-1:0]    pulse_width;
    logic                  measured;

    // register copies, as the block should hold them
    logic [THR_W-1:0]    cfg_high_thr;
    logic [THR_W-1:0]    cfg_low_thr;
    logic [EPM_W-1:0]    cfg_edges;
    logic [CLK_HZ_W-1:0] cfg_clock_hz;
    logic [PERIOD_W-1:0] cfg_pwm_period;
    logic [DUTY_W-1:0]   cfg_duty_min;
    logic [DUTY_W-1:0]   cfg_duty_max;

    // tracking state copies
    logic              trk_level;
    logic [EPM_W-1:0]  trk_edge_count;
    logic [TS_W-1:0]   trk_start_ts;
    logic [RPM_W-1:0]  trk_rpm;
    logic [DUTY_W-1:0] trk_duty;

    readout_t pending_readouts[$];
    int       fail_count;
    bit       gaps_enabled;
    bit       sink_hold_req;

    // waveform generator state
    logic [TS_W-1:0] wave_ts;
    bit              wave_high;

    tachometer_rpm_display i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .timestamp    (timestamp),
        .button_down  (button_down),
        .button_up    (button_up),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rpm          (rpm),
        .digit_left   (digit_left),
        .digit_middle (digit_middle),
        .digit_right  (digit_right),
        .pulse_width  (pulse_width),
        .measured     (measured)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // round(60 * clock_hz / ticks), half up, saturated; zero ticks saturate
    function automatic logic [RPM_W-1:0] rpm_from_ticks(input logic [TS_W-1:0] ticks);
        longint unsigned num;
        longint unsigned tk;
        longint unsigned q;
        longint unsigned r;
        tk = ticks;
        num = 64'd60 * cfg_clock_hz;
        if (tk == 0)
            return tach_pkg::RPM_CAP;
        q = num / tk;
        r = num % tk;
        if (r >= tk - r)
            q = q + 1;
        return (q > tach_pkg::RPM_CAP) ? tach_pkg::RPM_CAP : RPM_W'(q);
    endfunction

    // advance the tracking state by one item and form its readout
    function automatic readout_t tach_step(input logic [SMP_W-1:0] smp,
                                           input logic [TS_W-1:0] ts,
                                           input logic dn, input logic upb);
        readout_t         ro;
        logic             cls;
        logic [DUTY_W:0]  bumped;
        int unsigned      v;
        ro = '0;
        cls = trk_level;
        // the high test wins when the thresholds overlap
        if (smp > cfg_high_thr)
            cls = 1'b0;
        else if (smp < cfg_low_thr)
            cls = 1'b1;

        if (cls != trk_level)
        begin
            if (trk_edge_count == 0)
                trk_start_ts = ts;
            trk_edge_count = trk_edge_count + 8'd1;
            if (trk_edge_count >= cfg_edges)
            begin
                trk_rpm = rpm_from_ticks(ts - trk_start_ts);
                trk_edge_count = '0;
                ro.measured = 1'b1;
            end
        end
        else if (trk_duty == cfg_duty_max)
            trk_rpm = '0;
        trk_level = cls;

        // down first, then up; each clamps only on its own side
        if (dn)
        begin
            if (trk_duty == 0 || trk_duty - 13'd1 < cfg_duty_min)
                trk_duty = cfg_duty_min;
            else
                trk_duty = trk_duty - 13'd1;
        end
        if (upb)
        begin
            bumped = {1'b0, trk_duty} + 14'd1;
            trk_duty = (bumped > cfg_duty_max) ? cfg_duty_max : bumped[DUTY_W-1:0];
        end

        v = trk_rpm;
        ro.rpm = trk_rpm;
        if (trk_rpm >= tach_pkg::RPM_FOUR_DIGIT)
        begin
            ro.dig_left   = DIGIT_W'((v / 1000) % 10);
            ro.dig_middle = DIGIT_W'((v / 100) % 10);
            ro.dig_right  = DIGIT_W'((v / 10) % 10);
        end
        else
        begin
            ro.dig_left   = DIGIT_W'((v / 100) % 10);
            ro.dig_middle = DIGIT_W'((v / 10) % 10);
            ro.dig_right  = DIGIT_W'(v % 10);
        end
        ro.pulse = PULSE_W'((64'd1 * trk_duty * cfg_pwm_period) / 10000);
        return ro;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Offer one item, optionally after a random gap, and hold it until taken.
    // Valid stays high afterwards so back-to-back items need no extra cycle.
    task automatic send_item(input logic [SMP_W-1:0] smp, input logic [TS_W-1:0] ts,
                             input logic dn, input logic upb);
        int gap;
        @(negedge clk);
        if (gaps_enabled && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        sample      <= smp;
        timestamp   <= ts;
        button_down <= dn;
        button_up   <= upb;
        do
            @(posedge clk);
        while (in_stall);
        pending_readouts.push_back(tach_step(smp, ts, dn, upb));
    endtask

    // Drop valid and hold until every predicted readout has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge clk);
    endtask

    // Write one register and mirror it, masked to its width.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            tach_pkg::REG_HIGH_THR:   cfg_high_thr   = value[THR_W-1:0];
            tach_pkg::REG_LOW_THR:    cfg_low_thr    = value[THR_W-1:0];
            tach_pkg::REG_EDGES:      cfg_edges      = value[EPM_W-1:0];
            tach_pkg::REG_CLOCK_HZ:   cfg_clock_hz   = value[CLK_HZ_W-1:0];
            tach_pkg::REG_PWM_PERIOD: cfg_pwm_period = value[PERIOD_W-1:0];
            tach_pkg::REG_DUTY_MIN:   cfg_duty_min   = value[DUTY_W-1:0];
            tach_pkg::REG_DUTY_MAX:   cfg_duty_max   = value[DUTY_W-1:0];
            default:                  ;
        endcase
    endtask

    // Pick a sample that lands in the given hysteresis zone, where possible.
    function automatic logic [SMP_W-1:0] pick_sample(input zone_t zone);
        case (zone)
            ZONE_ABOVE:
                return (cfg_high_thr >= SMP_MAX) ? SMP_W'(SMP_MAX)
                       : SMP_W'($urandom_range(cfg_high_thr + 1, SMP_MAX));
            ZONE_BELOW:
                return (cfg_low_thr == 0) ? '0 : SMP_W'($urandom_range(0, cfg_low_thr - 1));
            default:
                return SMP_W'($urandom_range(cfg_low_thr, cfg_high_thr));
        endcase
    endfunction

    // Mostly a clean rotating sensor: alternating above/below samples with
    // band samples between, time advancing at a rate chosen for a target
    // speed. The rest is noise: any sample, and time either jumping anywhere or creeping forward a little.
    task automatic drive_rotation(input int count);
        longint unsigned per_edge;
        longint unsigned edges_eff;
        int unsigned     rpm_goal;
        logic [SMP_W-1:0] smp;
        logic [TS_W-1:0]  step;
        logic             dn;
        logic             upb;
        int               n;
        per_edge = 0;
        for (n = 0; n < count; n++)
        begin
            // retarget the speed every twenty items
            if (n % 20 == 0)
            begin
                rpm_goal = $urandom_range(1, 12000);
                edges_eff = (cfg_edges == 0) ? 1 : cfg_edges;
                per_edge = (64'd60 * cfg_clock_hz) / (rpm_goal * edges_eff);
                if (per_edge > 64'h3FFF_FFFF)
                    per_edge = 64'h3FFF_FFFF;
            end
            dn  = ($urandom_range(0, 5) == 0);
            upb = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 8)
            begin
                if ($urandom_range(0, 3) == 0)
                    smp = pick_sample(ZONE_BAND);
                else
                begin
                    wave_high = ~wave_high;
                    smp = pick_sample(wave_high ? ZONE_ABOVE : ZONE_BELOW);
                end
                step = TS_W'(per_edge / 2) + $urandom_range(0, 32'(per_edge / 8));
                wave_ts = wave_ts + step;
            end
            else
            begin
                smp = SMP_W'($urandom);
                if ($urandom_range(0, 1) == 0)
                    wave_ts = $urandom;
                else
                    wave_ts = wave_ts + $urandom_range(0, 255);
            end
            send_item(smp, wave_ts, dn, upb);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default registers: thresholds exactly at and beyond each edge,
    // buttons alone and together, a four-digit readout, saturation across
    // a timestamp wrap, and a half that rounds up on a three-digit readout.
    task automatic test_directed_readout();
        send_item('1, 32'd0, 1'b0, 1'b0);
        send_item('0, 32'd1000, 1'b1, 1'b0);
        send_item(12'd2000, 32'd2000, 1'b0, 1'b1);
        send_item(12'd2001, 32'd3000, 1'b1, 1'b1);
        send_item(12'd800, 32'd4000, 1'b0, 1'b0);
        send_item(12'd799, 32'd5000, 1'b0, 1'b0);
        send_item('1, 32'd6000, 1'b0, 1'b0);
        send_item('0, 32'd2_401_000, 1'b0, 1'b0);
        // measurement straddling the timestamp wrap
        send_item('1, 32'hFFFF_0000, 1'b0, 1'b0);
        send_item('0, 32'hFFFF_4000, 1'b0, 1'b0);
        send_item('1, 32'hFFFF_8000, 1'b0, 1'b0);
        send_item('0, 32'hFFFF_C000, 1'b0, 1'b0);
        send_item('1, 32'h0000_5000, 1'b0, 1'b0);
        // 2.4e9 / 2.56e6 = 937.5
        send_item('0, 32'd10_000_000, 1'b0, 1'b0);
        send_item('1, 32'd10_500_000, 1'b0, 1'b0);
        send_item('0, 32'd11_000_000, 1'b0, 1'b0);
        send_item('1, 32'd11_500_000, 1'b0, 1'b0);
        send_item('0, 32'd12_560_000, 1'b0, 1'b0);
        wait_drained();
    endtask

    // Register corners: unused index, masking, overlapping thresholds, zero
    // edge count, zero clock, zero elapsed time, duty outside its range,
    // step down from zero, forced zero at the duty maximum, top clamp.
    task automatic test_register_corners();
        write_reg(REG_SPARE, 27'd123);
        write_reg(tach_pkg::REG_HIGH_THR, 27'h123_4ABC);
        write_reg(tach_pkg::REG_LOW_THR, 27'd3000);
        write_reg(tach_pkg::REG_EDGES, 27'h100);
        write_reg(tach_pkg::REG_CLOCK_HZ, 27'd0);
        write_reg(tach_pkg::REG_DUTY_MIN, 27'd600);
        send_item(12'd2900, 32'h10, 1'b0, 1'b0);
        send_item(12'd100, 32'h20, 1'b0, 1'b0);
        send_item(12'd2900, 32'h30, 1'b1, 1'b0);
        wait_drained();

        write_reg(tach_pkg::REG_CLOCK_HZ, 27'd100_000_000);
        write_reg(tach_pkg::REG_EDGES, 27'd1);
        write_reg(tach_pkg::REG_DUTY_MAX, 27'd0);
        write_reg(tach_pkg::REG_DUTY_MIN, 27'd5);
        send_item(12'd100, 32'h40, 1'b0, 1'b1);
        send_item(12'd100, 32'h50, 1'b1, 1'b0);
        send_item(12'd100, 32'h60, 1'b0, 1'b0);
        wait_drained();

        write_reg(tach_pkg::REG_PWM_PERIOD, 27'd65535);
        write_reg(tach_pkg::REG_DUTY_MAX, 27'd8191);
        write_reg(tach_pkg::REG_DUTY_MIN, 27'd8191);
        send_item(12'd100, 32'h70, 1'b1, 1'b0);
        send_item(12'd100, 32'h80, 1'b0, 1'b1);
        wait_drained();
    endtask

    // Several register settings: defaults, upper and lower extremes, then
    // random ones with the duty limits placed close to the current duty.
    task automatic test_random_settings();
        int k;
        int lo;
        int hi;
        for (k = 0; k < 6; k++)
        begin
            wait_drained();
            case (k)
                0:
                begin
                    write_reg(tach_pkg::REG_HIGH_THR, CFG_DATA_W'(tach_pkg::HIGH_THR_RST));
                    write_reg(tach_pkg::REG_LOW_THR, CFG_DATA_W'(tach_pkg::LOW_THR_RST));
                    write_reg(tach_pkg::REG_EDGES, CFG_DATA_W'(tach_pkg::EPM_RST));
                    write_reg(tach_pkg::REG_CLOCK_HZ, CFG_DATA_W'(tach_pkg::CLK_HZ_RST));
                    write_reg(tach_pkg::REG_PWM_PERIOD, CFG_DATA_W'(tach_pkg::PERIOD_RST));
                    write_reg(tach_pkg::REG_DUTY_MIN, CFG_DATA_W'(tach_pkg::DUTY_MIN_RST));
                    write_reg(tach_pkg::REG_DUTY_MAX, CFG_DATA_W'(tach_pkg::DUTY_MAX_RST));
                end
                1:
                begin
                    write_reg(tach_pkg::REG_HIGH_THR, 27'd4094);
                    write_reg(tach_pkg::REG_LOW_THR, 27'd4095);
                    write_reg(tach_pkg::REG_EDGES, 27'd255);
                    write_reg(tach_pkg::REG_CLOCK_HZ, 27'h7FF_FFFF);
                    write_reg(tach_pkg::REG_PWM_PERIOD, 27'd65535);
                    write_reg(tach_pkg::REG_DUTY_MIN, 27'd8191);
                    write_reg(tach_pkg::REG_DUTY_MAX, 27'd8191);
                end
                2:
                begin
                    write_reg(tach_pkg::REG_HIGH_THR, 27'd0);
                    write_reg(tach_pkg::REG_LOW_THR, 27'd1);
                    write_reg(tach_pkg::REG_EDGES, 27'd1);
                    write_reg(tach_pkg::REG_CLOCK_HZ, 27'd1);
                    write_reg(tach_pkg::REG_PWM_PERIOD, 27'd1);
                    write_reg(tach_pkg::REG_DUTY_MIN, 27'd0);
                    write_reg(tach_pkg::REG_DUTY_MAX, 27'd0);
                end
                default:
                begin
                    hi = $urandom_range(1500, 3500);
                    write_reg(tach_pkg::REG_HIGH_THR, CFG_DATA_W'(hi));
                    write_reg(tach_pkg::REG_LOW_THR, CFG_DATA_W'($urandom_range(200, hi + 300)));
                    write_reg(tach_pkg::REG_EDGES, CFG_DATA_W'($urandom_range(1, 12)));
                    write_reg(tach_pkg::REG_CLOCK_HZ,
                              CFG_DATA_W'(($urandom_range(1, 100_000_000)
                                           >> $urandom_range(0, 12)) | 1));
                    write_reg(tach_pkg::REG_PWM_PERIOD, CFG_DATA_W'($urandom_range(1, 65535)));
                    lo = int'(trk_duty) - int'($urandom_range(0, 30));
                    hi = int'(trk_duty) + int'($urandom_range(0, 30));
                    write_reg(tach_pkg::REG_DUTY_MIN, CFG_DATA_W'((lo < 0) ? 0 : lo));
                    write_reg(tach_pkg::REG_DUTY_MAX, CFG_DATA_W'((hi > 8191) ? 8191 : hi));
                end
            endcase
            drive_rotation(240);
        end
        wait_drained();
    endtask

    // Hold the output off for a long stretch while items keep coming, so
    // the block fills up and stalls its input.
    task automatic test_output_backpressure();
        sink_hold_req = 1'b1;
        drive_rotation(80);
        wait_drained();
    endtask

    // Pause the source until every readout is back, then resume.
    task automatic test_source_pause();
        drive_rotation(30);
        wait_drained();
        drive_rotation(30);
        wait_drained();
    endtask

    // Run the last stretch with no gaps on either side.
    task automatic test_steady_stream();
        gaps_enabled = 1'b0;
        drive_rotation(200);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Result checking: compare each taken result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_readout
        readout_t got;
        readout_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{rpm, digit_left, digit_middle, digit_right, pulse_width, measured};
            if (pending_readouts.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result rpm=%0d digits=%0d%0d%0d pulse=%0d meas=%0b",
                             $realtime, got.rpm, got.dig_left, got.dig_middle,
                             got.dig_right, got.pulse, got.measured);
            end
            else
            begin
                want = pending_readouts.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: expected rpm=%0d digits=%0d%0d%0d pulse=%0d meas=%0b",
                                 $realtime, want.rpm, want.dig_left, want.dig_middle,
                                 want.dig_right, want.pulse, want.measured);
                        $display("%0t:   actual rpm=%0d digits=%0d%0d%0d pulse=%0d meas=%0b",
                                 $realtime, got.rpm, got.dig_left, got.dig_middle,
                                 got.dig_right, got.pulse, got.measured);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stall: random short bursts, or one long hold when requested
    // ------------------------------------------------------------------
    initial
    begin : stall_driver
        int burst;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (SINK_HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (gaps_enabled && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                burst = $urandom_range(1, 7);
                repeat (burst) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if it hangs
    // ------------------------------------------------------------------
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // hold every input at a known value from time zero
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        sample       = '0;
        timestamp    = '0;
        button_down  = 1'b0;
        button_up    = 1'b0;
        fail_count   = 0;
        gaps_enabled = 1'b1;
        sink_hold_req = 1'b0;
        wave_ts      = '0;
        wave_high    = 1'b0;

        // reset state and register copies
        cfg_high_thr   = tach_pkg::HIGH_THR_RST;
        cfg_low_thr    = tach_pkg::LOW_THR_RST;
        cfg_edges      = tach_pkg::EPM_RST;
        cfg_clock_hz   = tach_pkg::CLK_HZ_RST;
        cfg_pwm_period = tach_pkg::PERIOD_RST;
        cfg_duty_min   = tach_pkg::DUTY_MIN_RST;
        cfg_duty_max   = tach_pkg::DUTY_MAX_RST;
        trk_level      = 1'b0;
        trk_edge_count = '0;
        trk_start_ts   = '0;
        trk_rpm        = '0;
        trk_duty       = tach_pkg::DUTY_RST;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_readout();
        test_register_corners();
        test_random_settings();
        test_output_backpressure();
        test_source_pause();
        test_steady_stream();

        // let any stray result show up before judging
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_readouts.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
